@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// plain property check
`define GSC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// same-cycle implication
`define GSC_ASSERT_IMPL(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`else
`define GSC_ASSERT(lbl, prop)
`define GSC_ASSERT_IMPL(lbl, a, b)
`endif
`endif

@@ design/gsc_pkg.sv @@
// ---------------------------------------------------------------------------
// gsc_pkg
// Shared types, constants and the exponential table for the coherence unit.
// ---------------------------------------------------------------------------
package gsc_pkg;

  localparam int EXP_TABLE_DEPTH = 256;
  localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
  localparam int POS_W = 24 + IDX_W;

  localparam logic [31:0] S_FIXED   = 32'd2305371830;
  localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
  localparam logic [63:0] LN2_Q32   = 64'd2977044472;
  localparam logic [27:0] T_CLAMP   = 28'h8000000;

  typedef enum logic [1:0] {
    REG_MAJOR = 2'd0,
    REG_MINOR = 2'd1,
    REG_COS   = 2'd2,
    REG_SIN   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0]        major;
    logic [31:0]        minor;
    logic signed [31:0] cos_phi;
    logic signed [31:0] sin_phi;
  } cfg_t;

  typedef struct packed {
    logic signed [32:0] s_add;  // I + Q
    logic signed [32:0] s_sub;  // I - Q
    logic signed [31:0] s_u;
    logic signed [31:0] s_v;
  } stokes_t;

  typedef logic [32:0] rom_t [EXP_TABLE_DEPTH+1];

  // 2^(-k/DEPTH) in Q.32 by a truncated Taylor series, evaluated at elaboration
  function automatic rom_t build_exp_rom();
    rom_t        rom;
    logic [63:0] z;
    logic [63:0] term;
    longint      sum;
    for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
      z    = (64'(k) * LN2_Q32) / EXP_TABLE_DEPTH;
      sum  = 64'sh1_0000_0000;
      term = 64'h1_0000_0000;
      for (int n = 1; n <= 20; n++) begin
        term = ((term * z) >> 32) / 64'(n);
        if (n % 2 == 1) sum = sum - longint'(term);
        else            sum = sum + longint'(term);
      end
      rom[k] = sum[32:0];
    end
    return rom;
  endfunction

endpackage

@@ design/gsc_geom.sv @@
// ---------------------------------------------------------------------------
// gsc_geom
// Baseline, rotation and scaling to sigma units; five pipeline stages.
// ---------------------------------------------------------------------------
module gsc_geom import gsc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] u_a,
  input  logic signed [31:0] v_a,
  input  logic signed [31:0] u_b,
  input  logic signed [31:0] v_b,
  input  logic [31:0]        freq_hz,
  input  stokes_t            in_st,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [27:0]        tu,
  output logic [27:0]        tv,
  output stokes_t            out_st
);

  localparam int N = 5;

  logic [N:1]   v_r;
  logic [N+1:1] en;
  stokes_t      st_r [N];

  always_comb begin
    en[N+1] = out_ready;
    for (int k = N; k >= 1; k--) en[k] = !v_r[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) v_r[1] <= in_valid;
      for (int k = 2; k <= N; k++) if (en[k]) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) st_r[0] <= in_st;
    for (int k = 1; k < N; k++) if (en[k+1]) st_r[k] <= st_r[k-1];
  end

  // stage 1: baseline and fwhm*freq
  logic signed [32:0] du_r, dv_r;
  logic [63:0]        pu_r, pv_r;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      du_r <= {u_b[31], u_b} - {u_a[31], u_a};
      dv_r <= {v_b[31], v_b} - {v_a[31], v_a};
      pu_r <= 64'(cfg.major) * 64'(freq_hz);
      pv_r <= 64'(cfg.minor) * 64'(freq_hz);
    end
  end

  // stage 2: rotation products, partial products of the scale factor
  logic signed [64:0] mcu_r, msv_r, msu_r, mcv_r;
  logic [63:0]        pul_r, puh_r, pvl_r, pvh_r;
  always_ff @(posedge clk) begin
    if (en[2]) begin
      mcu_r <= 65'(du_r) * 65'(cfg.cos_phi);
      msv_r <= 65'(dv_r) * 65'(cfg.sin_phi);
      msu_r <= 65'(du_r) * 65'(cfg.sin_phi);
      mcv_r <= 65'(dv_r) * 65'(cfg.cos_phi);
      pul_r <= 64'(pu_r[31:0])  * 64'(S_FIXED);
      puh_r <= 64'(pu_r[63:32]) * 64'(S_FIXED);
      pvl_r <= 64'(pv_r[31:0])  * 64'(S_FIXED);
      pvh_r <= 64'(pv_r[63:32]) * 64'(S_FIXED);
    end
  end

  // stage 3: rotated axes (floor shift), scale g in Q.32
  logic signed [35:0] ur_c, vr_c;
  logic [95:0]        gu_full, gv_full;
  logic [35:0]        ru_r, rv_r, gu_r, gv_r;
  always_comb begin
    ur_c = 36'(mcu_r >>> 30) - 36'(msv_r >>> 30);
    vr_c = 36'(msu_r >>> 30) + 36'(mcv_r >>> 30);
    gu_full = {puh_r, 32'd0} + 96'(pul_r);
    gv_full = {pvh_r, 32'd0} + 96'(pvl_r);
  end
  always_ff @(posedge clk) begin
    if (en[3]) begin
      ru_r <= ur_c[35] ? 36'(-ur_c) : 36'(ur_c);
      rv_r <= vr_c[35] ? 36'(-vr_c) : 36'(vr_c);
      gu_r <= gu_full[95:60];
      gv_r <= gv_full[95:60];
    end
  end

  // stage 4: g*|r| split into two halves of r
  logic [53:0] plu_r, phu_r, plv_r, phv_r;
  always_ff @(posedge clk) begin
    if (en[4]) begin
      plu_r <= 54'(gu_r) * 54'(ru_r[17:0]);
      phu_r <= 54'(gu_r) * 54'(ru_r[35:18]);
      plv_r <= 54'(gv_r) * 54'(rv_r[17:0]);
      phv_r <= 54'(gv_r) * 54'(rv_r[35:18]);
    end
  end

  // stage 5: combine, to Q.24, clamp at 8.0
  logic [71:0] su_c, sv_c;
  logic [55:0] qu_c, qv_c;
  logic [27:0] tu_r, tv_r;
  always_comb begin
    su_c = {phu_r, 18'd0} + 72'(plu_r);
    sv_c = {phv_r, 18'd0} + 72'(plv_r);
    qu_c = su_c[71:16];
    qv_c = sv_c[71:16];
  end
  always_ff @(posedge clk) begin
    if (en[5]) begin
      tu_r <= (qu_c > 56'(T_CLAMP)) ? T_CLAMP : qu_c[27:0];
      tv_r <= (qv_c > 56'(T_CLAMP)) ? T_CLAMP : qv_c[27:0];
    end
  end

  assign in_ready  = en[1];
  assign out_valid = v_r[N];
  assign tu        = tu_r;
  assign tv        = tv_r;
  assign out_st    = st_r[N-1];

endmodule

@@ design/gsc_coh.sv @@
// ---------------------------------------------------------------------------
// gsc_coh
// Coherence exp(-(tu^2+tv^2)) via base-2 range reduction and table lookup.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module gsc_coh import gsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [27:0] tu,
  input  logic [27:0] tv,
  input  stokes_t     in_st,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [32:0] coh,
  output stokes_t     out_st
);

  localparam int N = 6;
  localparam rom_t EXP_ROM = build_exp_rom();

  logic [N:1]   v_r;
  logic [N+1:1] en;
  stokes_t      st_r [N];

  always_comb begin
    en[N+1] = out_ready;
    for (int k = N; k >= 1; k--) en[k] = !v_r[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) v_r[1] <= in_valid;
      for (int k = 2; k <= N; k++) if (en[k]) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) st_r[0] <= in_st;
    for (int k = 1; k < N; k++) if (en[k+1]) st_r[k] <= st_r[k-1];
  end

  // stage 1: squares
  logic [55:0] squ_r, sqv_r;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      squ_r <= 56'(tu) * 56'(tu);
      sqv_r <= 56'(tv) * 56'(tv);
    end
  end

  // stage 2: x in Q.24
  logic [56:0] ssum_c;
  logic [31:0] x_r;
  assign ssum_c = 57'(squ_r) + 57'(sqv_r);
  always_ff @(posedge clk) begin
    if (en[2]) x_r <= ssum_c[55:24];
  end

  // stage 3: y = x*log2(e)
  logic [63:0] ym_c;
  logic [31:0] y_r;
  assign ym_c = 64'(x_r) * 64'(LOG2E_Q30);
  always_ff @(posedge clk) begin
    if (en[3]) y_r <= ym_c[61:30];
  end

  // stage 4: table lookup of both interpolation points
  logic [POS_W-1:0] pos_c;
  logic [IDX_W:0]   idx_c;
  logic [32:0]      e0_r, e1_r;
  logic [23:0]      rem_r;
  logic [5:0]       n_r;
  logic             zero_r;
  always_comb begin
    pos_c = POS_W'(y_r[23:0]) * POS_W'(EXP_TABLE_DEPTH);
    idx_c = {1'b0, pos_c[POS_W-1:24]};
  end
  always_ff @(posedge clk) begin
    if (en[4]) begin
      e0_r   <= EXP_ROM[idx_c];
      e1_r   <= EXP_ROM[idx_c + 1'b1];
      rem_r  <= pos_c[23:0];
      n_r    <= y_r[29:24];
      zero_r <= (y_r[31:24] >= 8'd33);
    end
  end

  // stage 5: slope times remainder
  logic [32:0] d_c, e0b_r;
  logic [56:0] dr_r;
  logic [5:0]  nb_r;
  logic        zerob_r;
  assign d_c = (e0_r > e1_r) ? e0_r - e1_r : 33'd0;
  always_ff @(posedge clk) begin
    if (en[5]) begin
      dr_r    <= 57'(d_c) * 57'(rem_r);
      e0b_r   <= e0_r;
      nb_r    <= n_r;
      zerob_r <= zero_r;
    end
  end

  // stage 6: interpolate and shift down by the integer part
  logic [32:0] ip_c, coh_r;
  assign ip_c = e0b_r - dr_r[56:24];
  always_ff @(posedge clk) begin
    if (en[6]) coh_r <= zerob_r ? 33'd0 : (ip_c >> nb_r);
  end

  assign in_ready  = en[1];
  assign out_valid = v_r[N];
  assign coh       = coh_r;
  assign out_st    = st_r[N-1];

  `GSC_ASSERT_IMPL(a_coh_max, v_r[N], coh_r <= 33'h1_0000_0000)
  `GSC_ASSERT_IMPL(a_zero_flag, v_r[N] && $past(en[6] && zerob_r), coh_r == 33'd0)
  `GSC_ASSERT_IMPL(a_rem_slope, v_r[5], dr_r[56:24] <= 57'(e0b_r))

endmodule

@@ design/gsc_jones.sv @@
// ---------------------------------------------------------------------------
// gsc_jones
// Coherence times half Stokes combinations, rounded and saturated to Q16.16.
// ---------------------------------------------------------------------------
module gsc_jones import gsc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [32:0]        coh,
  input  stokes_t            in_st,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] xx_value,
  output logic signed [31:0] yy_value,
  output logic signed [31:0] xy_real,
  output logic signed [31:0] xy_imag,
  output logic signed [31:0] yx_real,
  output logic signed [31:0] yx_imag
);

  localparam int N = 2;

  logic [N:1]   v_r;
  logic [N+1:1] en;

  always_comb begin
    en[N+1] = out_ready;
    for (int k = N; k >= 1; k--) en[k] = !v_r[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) v_r[1] <= in_valid;
      if (en[2]) v_r[2] <= v_r[1];
    end
  end

  function automatic logic [32:0] mag33(logic signed [32:0] s);
    return s[32] ? 33'(-s) : 33'(s);
  endfunction

  // round half away, clamp magnitude, restore sign, saturate
  function automatic logic signed [31:0] finish(logic [65:0] p, logic neg);
    logic [66:0] r;
    logic [31:0] m;
    r = (67'(p) + 67'h1_0000_0000) >> 33;
    m = (r > 67'h8000_0000) ? 32'h8000_0000 : r[31:0];
    if (neg)                   return 32'(-m);
    else if (m[31])            return 32'sh7FFF_FFFF;
    else                       return $signed(m);
  endfunction

  // stage 1: magnitude products
  logic [65:0] pa_r, ps_r, pu_r, pv_r;
  logic        na_r, ns_r, nu_r, nv_r;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      pa_r <= 66'(coh) * 66'(mag33(in_st.s_add));
      ps_r <= 66'(coh) * 66'(mag33(in_st.s_sub));
      pu_r <= 66'(coh) * 66'(mag33(33'(in_st.s_u)));
      pv_r <= 66'(coh) * 66'(mag33(33'(in_st.s_v)));
      na_r <= in_st.s_add[32];
      ns_r <= in_st.s_sub[32];
      nu_r <= in_st.s_u[31];
      nv_r <= in_st.s_v[31];
    end
  end

  // stage 2: output register
  logic signed [31:0] xyi_c;
  logic signed [31:0] xx_r, yy_r, xyr_r, xyi_r, yxi_r;
  assign xyi_c = finish(pv_r, nv_r);
  always_ff @(posedge clk) begin
    if (en[2]) begin
      xx_r  <= finish(pa_r, na_r);
      yy_r  <= finish(ps_r, ns_r);
      xyr_r <= finish(pu_r, nu_r);
      xyi_r <= xyi_c;
      yxi_r <= (xyi_c == 32'sh8000_0000) ? 32'sh7FFF_FFFF : 32'(-xyi_c);
    end
  end

  assign in_ready  = en[1];
  assign out_valid = v_r[N];
  assign xx_value  = xx_r;
  assign yy_value  = yy_r;
  assign xy_real   = xyr_r;
  assign xy_imag   = xyi_r;
  assign yx_real   = xyr_r;
  assign yx_imag   = yxi_r;

endmodule

@@ design/gaussian_source_coherence_unit.sv @@
// ---------------------------------------------------------------------------
// gaussian_source_coherence_unit
// Elliptical Gaussian source coherence times Stokes, one sample per cycle while out_tready is high.
// ---------------------------------------------------------------------------
// Usage:
//  - in_* stream: one request per time-channel sample (station u,v pairs,
//    frequency, Stokes I,Q,U,V), packed in in_tdata.
//  - out_* stream: XX, YY, XY re/im, YX re/im in Q16.16, packed in out_tdata.
//  - cfg_*: write major/minor FWHM and cos/sin of the orientation while the
//    pipeline is empty; takes effect on the next request.
//  - Stages: 13 register stages from input accept to out_tvalid (5 geometry,
//    6 exponent, 2 product/output); the first loads at accept.
//  - Throughput: one request per cycle while out_tready is high; each stage
//    advances independently, so a bubble is squeezed out when the receiver stalls.
//  - Stall: when out_tready is low and all 13 stages hold data, in_tready
//    drops; nothing is lost or repeated.
//  - Reset (rst_n low, synchronous): pipeline emptied, registers return
//    to major=minor=0, cos=0, sin=1.0. The exponent table is constant logic.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module gaussian_source_coherence_unit import gsc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // u_a, v_a, u_b, v_b, freq_hz, stokes_i, stokes_q, stokes_u, stokes_v
  input  logic [287:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // xx_value, yy_value, xy_real, xy_imag, yx_real, yx_imag
  output logic [191:0] out_tdata
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.major   <= '0;
      cfg_r.minor   <= '0;
      cfg_r.cos_phi <= '0;
      cfg_r.sin_phi <= 32'sh4000_0000;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_MAJOR: cfg_r.major   <= cfg_wdata;
        REG_MINOR: cfg_r.minor   <= cfg_wdata;
        REG_COS:   cfg_r.cos_phi <= $signed(cfg_wdata);
        REG_SIN:   cfg_r.sin_phi <= $signed(cfg_wdata);
        default:   ;
      endcase
    end
  end

  logic signed [31:0] si, sq;
  stokes_t            st_in;
  assign si = $signed(in_tdata[191:160]);
  assign sq = $signed(in_tdata[223:192]);
  always_comb begin
    st_in.s_add = {si[31], si} + {sq[31], sq};
    st_in.s_sub = {si[31], si} - {sq[31], sq};
    st_in.s_u   = $signed(in_tdata[255:224]);
    st_in.s_v   = $signed(in_tdata[287:256]);
  end

  logic        g_valid, g_ready, c_valid, c_ready;
  logic [27:0] tu, tv;
  stokes_t     g_st, c_st;
  logic [32:0] coh;

  gsc_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .u_a       ($signed(in_tdata[31:0])),
    .v_a       ($signed(in_tdata[63:32])),
    .u_b       ($signed(in_tdata[95:64])),
    .v_b       ($signed(in_tdata[127:96])),
    .freq_hz   (in_tdata[159:128]),
    .in_st     (st_in),
    .out_valid (g_valid),
    .out_ready (g_ready),
    .tu        (tu),
    .tv        (tv),
    .out_st    (g_st)
  );

  gsc_coh u_coh (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (g_valid),
    .in_ready  (g_ready),
    .tu        (tu),
    .tv        (tv),
    .in_st     (g_st),
    .out_valid (c_valid),
    .out_ready (c_ready),
    .coh       (coh),
    .out_st    (c_st)
  );

  logic signed [31:0] xx, yy, xyr, xyi, yxr, yxi;

  gsc_jones u_jones (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (c_valid),
    .in_ready  (c_ready),
    .coh       (coh),
    .in_st     (c_st),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .xx_value  (xx),
    .yy_value  (yy),
    .xy_real   (xyr),
    .xy_imag   (xyi),
    .yx_real   (yxr),
    .yx_imag   (yxi)
  );

  assign out_tdata = {yxi, yxr, xyi, xyr, yy, xx};

  `GSC_ASSERT_IMPL(a_empty_ready, !out_tvalid, in_tready)
  `GSC_ASSERT_IMPL(a_yx_real, out_tvalid, yxr == xyr)
  `GSC_ASSERT_IMPL(a_yx_imag, out_tvalid && xyi != 32'sh8000_0000, yxi == -xyi)

endmodule

@@ dv/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// Checks the coherence unit against a bit-exact predictor of the fixed-point
// baseline rotation, axis scaling, table exponential and Stokes products.
// Random gaps on both streams, a long output stall and a drain pause.
// ---------------------------------------------------------------------------
module tb;
  import gsc_pkg::*;

  localparam logic [63:0] ONE = 64'h1_0000_0000;
  localparam logic [63:0] TCL = 64'(T_CLAMP);

  logic         clk;
  logic         rst_n;
  logic         cfg_wr_en;
  logic [1:0]   cfg_addr;
  logic [31:0]  cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  // u_a, v_a, u_b, v_b, freq_hz, stokes_i, stokes_q, stokes_u, stokes_v
  logic [287:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  // xx_value, yy_value, xy_real, xy_imag, yx_real, yx_imag
  logic [191:0] out_tdata;

  gaussian_source_coherence_unit dut (.*);

  logic [63:0]  exp_tab [EXP_TABLE_DEPTH+1];
  logic [31:0]  r_major, r_minor, r_cos, r_sin;
  logic [287:0] sample_q [$];
  logic [191:0] jones_q [$];
  int           errors;
  int           gap, hold, stall_cycles;
  bit           drained;
  bit           pause_in;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #400_000_000;
    $display("tb NOT OK");
    $finish;
  end

  function automatic logic [63:0] taylor_exp(logic [63:0] z);
    logic [63:0] term;
    longint      acc;
    term = ONE;
    acc = longint'(ONE);
    for (int n = 1; n <= 20; n++) begin
      term = ((term * z) >> 32) / 64'(n);
      if (n % 2) acc -= longint'(term);
      else       acc += longint'(term);
    end
    return 64'(acc);
  endfunction

  function automatic logic [63:0] scaled_axis(logic [31:0] fwhm, logic [31:0] f,
                                              logic [63:0] r);
    logic [127:0] p;
    logic [63:0]  g;
    p = 128'(64'(fwhm) * 64'(f)) * 128'(S_FIXED);
    g = 64'(p >> 60);
    p = 128'(g) * 128'(r);
    if (p[127:64] != 0) return TCL;
    g = p[63:0] >> 16;
    return g > TCL ? TCL : g;
  endfunction

  function automatic logic [31:0] sat(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] half_mul(logic [63:0] coh, longint s);
    logic [63:0]  mag;
    logic [127:0] p;
    logic [63:0]  r;
    mag = s < 0 ? 64'(-s) : 64'(s);
    p = 128'(coh) * 128'(mag) + 128'(ONE);
    r = 64'(p >> 33);
    if (r > 64'h8000_0000) r = 64'h8000_0000;
    return sat(s < 0 ? -longint'(r) : longint'(r));
  endfunction

  function automatic longint floor30(longint v);
    return v >>> 30;
  endfunction

  function automatic logic [191:0] coherence_jones(logic [287:0] d);
    longint du, dv, c, s, ur, vr, si, sq;
    logic [63:0] tu, tv, x, y, n, pos, idx, rem, e0, e1, dd, coh;
    logic [31:0] xyr, xyi;
    du = longint'(signed'(d[95:64])) - longint'(signed'(d[31:0]));
    dv = longint'(signed'(d[127:96])) - longint'(signed'(d[63:32]));
    c = longint'(signed'(r_cos));
    s = longint'(signed'(r_sin));
    ur = floor30(du * c) - floor30(dv * s);
    vr = floor30(du * s) + floor30(dv * c);
    tu = scaled_axis(r_major, d[159:128], ur < 0 ? 64'(-ur) : 64'(ur));
    tv = scaled_axis(r_minor, d[159:128], vr < 0 ? 64'(-vr) : 64'(vr));
    x = (tu * tu + tv * tv) >> 24;
    y = (x * 64'(LOG2E_Q30)) >> 30;
    n = y >> 24;
    pos = (y & 64'hFF_FFFF) * EXP_TABLE_DEPTH;
    idx = pos >> 24;
    rem = pos & 64'hFF_FFFF;
    coh = 0;
    if (idx < EXP_TABLE_DEPTH && n < 33) begin
      e0 = exp_tab[idx];
      e1 = exp_tab[idx+1];
      dd = e0 > e1 ? e0 - e1 : 0;
      coh = (e0 - ((dd * rem) >> 24)) >> n;
    end
    si = longint'(signed'(d[191:160]));
    sq = longint'(signed'(d[223:192]));
    xyr = half_mul(coh, longint'(signed'(d[255:224])));
    xyi = half_mul(coh, longint'(signed'(d[287:256])));
    return {sat(-longint'(signed'(xyi))), xyr, xyi, xyr,
            half_mul(coh, si - sq), half_mul(coh, si + sq)};
  endfunction

  // driver
  always @(posedge clk) begin
    int g;
    if (!rst_n) begin
      in_tvalid <= 0;
      gap <= 0;
    end else if (!in_tvalid || in_tready) begin
      // idle, or the current request was just taken
      g = in_tvalid ? $urandom_range(0, 10) * $urandom_range(0, 1) : gap;
      if (g > 0 || pause_in || sample_q.size() == 0) begin
        in_tvalid <= 0;
        gap <= g > 0 ? g - 1 : 0;
      end else begin
        in_tvalid <= 1;
        in_tdata <= sample_q.pop_front();
        gap <= 0;
      end
    end
  end

  // expectation at acceptance, predicted with the registers in force
  always @(posedge clk)
    if (rst_n && in_tvalid && in_tready) jones_q.push_back(coherence_jones(in_tdata));

  // receiver
  always @(posedge clk) begin
    int h;
    if (!rst_n) begin
      out_tready <= 0;
      hold <= 0;
    end else if (stall_cycles > 0) begin
      out_tready <= 0;
      stall_cycles <= stall_cycles - 1;
    end else if (hold > 0) begin
      out_tready <= 0;
      hold <= hold - 1;
    end else if (out_tvalid && out_tready) begin
      h = $urandom_range(0, 10) * $urandom_range(0, 1);
      hold <= h > 0 ? h - 1 : 0;
      out_tready <= (h == 0);
    end else begin
      out_tready <= 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [191:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (jones_q.size() == 0) begin
        $error("unexpected result %h", out_tdata);
        errors++;
      end else begin
        want = jones_q.pop_front();
        if (out_tdata[31:0] !== want[31:0]) begin
          $error("xx_value exp %h got %h", want[31:0], out_tdata[31:0]); errors++;
        end
        if (out_tdata[63:32] !== want[63:32]) begin
          $error("yy_value exp %h got %h", want[63:32], out_tdata[63:32]); errors++;
        end
        if (out_tdata[95:64] !== want[95:64]) begin
          $error("xy_real exp %h got %h", want[95:64], out_tdata[95:64]); errors++;
        end
        if (out_tdata[127:96] !== want[127:96]) begin
          $error("xy_imag exp %h got %h", want[127:96], out_tdata[127:96]); errors++;
        end
        if (out_tdata[159:128] !== want[159:128]) begin
          $error("yx_real exp %h got %h", want[159:128], out_tdata[159:128]); errors++;
        end
        if (out_tdata[191:160] !== want[191:160]) begin
          $error("yx_imag exp %h got %h", want[191:160], out_tdata[191:160]); errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rnd32();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 4000)) - 2000) << 8;
      3: return 32'($signed($urandom_range(0, 400000)) - 200000) << 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [287:0] rand_sample();
    logic [31:0] f;
    f = $urandom_range(0, 3) == 0 ? $urandom :
        ($urandom_range(0, 1) ? $urandom_range(10_000_000, 300_000_000) :
         $urandom_range(1_000_000, 4_000_000_000));
    return {rnd32(), rnd32(), rnd32(), rnd32(), f,
            rnd32(), rnd32(), rnd32(), rnd32()};
  endfunction

  task automatic write_reg(cfg_reg_t r, logic [31:0] v);
    @(posedge clk);
    cfg_wr_en <= 1;
    cfg_addr <= r;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
    case (r)
      REG_MAJOR: r_major = v;
      REG_MINOR: r_minor = v;
      REG_COS:   r_cos = v;
      default:   r_sin = v;
    endcase
  endtask

  task automatic wait_idle();
    int t;
    t = 0;
    while ((sample_q.size() != 0 || in_tvalid || jones_q.size() != 0) && t < 200000) begin
      @(posedge clk);
      t++;
    end
    repeat (20) @(posedge clk);
  endtask

  initial begin
    logic [31:0] maj, mnr;
    int          ph;
    errors = 0;
    pause_in = 0;
    stall_cycles = 0;
    rst_n = 0;
    cfg_wr_en = 0;
    cfg_addr = REG_MAJOR;
    cfg_wdata = 0;
    in_tvalid = 0;
    in_tdata = 0;
    out_tready = 0;
    r_major = 0;
    r_minor = 0;
    r_cos = 0;
    r_sin = 32'h4000_0000;
    for (int k = 0; k <= EXP_TABLE_DEPTH; k++)
      exp_tab[k] = taylor_exp((64'(k) * LN2_Q32) / EXP_TABLE_DEPTH);
    repeat (6) @(posedge clk);
    rst_n <= 1;

    // directed under reset registers (zero FWHM: coherence one)
    sample_q.push_back({32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                        32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                        32'h8000_0000, 32'h7fff_ffff});
    sample_q.push_back({32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'd0, 32'h7fff_ffff, 32'h8000_0000,
                        32'h7fff_ffff, 32'h8000_0000});
    sample_q.push_back({32'h0000_8000, 32'hffff_0000, 32'h0002_0000,
                        32'h0003_0000, 32'd150_000_000, 32'd100, 32'h0,
                        32'hffff_ff00, 32'd0});
    sample_q.push_back('1);
    sample_q.push_back('0);
    wait_idle();

    for (ph = 0; ph < 11; ph++) begin
      case (ph)
        0: begin maj = 32'hffff_ffff; mnr = 32'hffff_ffff; end // clamp to zero
        1: begin maj = 32'h0000_0001; mnr = 0; end
        2: begin maj = 32'd0; mnr = 32'hffff_ffff; end
        default: begin
          maj = $urandom_range(0, 1) ? $urandom_range(1, 32'h0050_0000) : $urandom;
          mnr = $urandom_range(0, 1) ? $urandom_range(1, 32'h0050_0000) : $urandom;
        end
      endcase
      write_reg(REG_MAJOR, maj);
      write_reg(REG_MINOR, mnr);
      case (ph)
        0: begin write_reg(REG_COS, 32'h4000_0000); write_reg(REG_SIN, 32'h0); end
        1: begin write_reg(REG_COS, 32'hc000_0000); write_reg(REG_SIN, 32'hc000_0000); end
        2: begin write_reg(REG_COS, 32'h8000_0000); write_reg(REG_SIN, 32'h7fff_ffff); end
        default: begin
          write_reg(REG_COS, 32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000));
          write_reg(REG_SIN, ph == 5 ? $urandom :
                    32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000));
        end
      endcase
      if (ph < 3) begin
        sample_q.push_back('1);
        sample_q.push_back({$urandom, $urandom, $urandom, $urandom,
                            32'd4000000000, 32'h0, 32'h100, 32'h0, 32'h0});
      end
      for (int i = 0; i < 49; i++) sample_q.push_back(rand_sample());
      if (ph == 4) begin
        // long receiver hold-off so the pipeline fills and in_tready drops
        stall_cycles = 60;
      end
      if (ph == 6) begin
        wait (sample_q.size() < 25);
        pause_in = 1;
        while (jones_q.size() != 0 || in_tvalid) @(posedge clk);
        pause_in = 0;
      end
      wait_idle();
    end

    wait_idle();
    if (errors == 0 && jones_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
